@@ sv/bpcw_pkg.sv @@
package bpcw_pkg;

   // Queue geometry between the front and the back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register map
   localparam logic CSR_CHANNEL  = 1'b0;
   localparam logic CSR_CRC_INIT = 1'b1;

   // Reset values of the registers
   localparam logic [5:0]  CHANNEL_RESET  = 6'd37;
   localparam logic [23:0] CRC_INIT_RESET = 24'h555555;

   // CRC-24 feedback and whitener tap
   localparam logic [23:0] CRC_POLY   = 24'h00065B;
   localparam logic [7:0]  WHITEN_TAP = 8'h11;
   localparam logic [7:0]  SEED_OR    = 8'h02;

   // Number of CRC bytes appended after the last payload byte
   localparam logic [1:0]  CRC_BYTES  = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       first;
   } entry_type;

   typedef struct packed {
      logic [5:0]  channel;
      logic [23:0] crc_init;
   } cfg_type;

   function automatic logic [7:0] rev8(input logic [7:0] a);
      logic [7:0] v;
      for (int k = 0; k < 8; k++) begin
         v[7 - k] = a[k];
      end
      return v;
   endfunction

   function automatic logic [7:0] whiten_seed(input logic [5:0] channel);
      return rev8({2'b00, channel}) | SEED_OR;
   endfunction

   // Feed one byte into the CRC, least significant bit first
   function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] d);
      logic [23:0] c;
      logic        top;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         top = c[23];
         c   = {c[22:0], 1'b0};
         if (top != d[k]) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Bits to invert in one byte for a given whitener state
   function automatic logic [7:0] whiten_mask(input logic [7:0] wht);
      logic [7:0] w;
      logic [7:0] m;
      w = wht;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         if (w[7]) begin
            w    = w ^ WHITEN_TAP;
            m[k] = 1'b1;
         end
         w = {w[6:0], 1'b0};
      end
      return m;
   endfunction

   // Whitener state after one byte
   function automatic logic [7:0] whiten_next(input logic [7:0] wht);
      logic [7:0] w;
      w = wht;
      for (int k = 0; k < 8; k++) begin
         if (w[7]) begin
            w = w ^ WHITEN_TAP;
         end
         w = {w[6:0], 1'b0};
      end
      return w;
   endfunction

endpackage

@@ sv/bpcw_front.sv @@
module bpcw_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // last_byte
   input  logic                fifo_full,
   output logic                push,
   output bpcw_pkg::entry_type push_entry
);

   logic open_ff;
   logic open_in;

   // Accept while the queue has room
   assign req_tready = !fifo_full;
   assign push       = req_tvalid && req_tready;

   // Mark the first byte of each packet
   assign push_entry.data  = req_tdata;
   assign push_entry.last  = req_tlast;
   assign push_entry.first = !open_ff;

   // Track whether a packet is open
   always_comb begin
      open_in = open_ff;
      if (push) begin
         open_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

endmodule

@@ sv/bpcw_fifo.sv @@
module bpcw_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bpcw_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output bpcw_pkg::entry_type pop_entry
);

   bpcw_pkg::entry_type                  entries_ff [bpcw_pkg::FIFO_DEPTH];
   logic [bpcw_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [bpcw_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [bpcw_pkg::FIFO_CNT_W-1:0]      count_ff,  count_in;
   logic                                 do_pop;

   assign full      = (count_ff == bpcw_pkg::FIFO_CNT_W'(bpcw_pkg::FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ sv/bpcw_back.sv @@
module bpcw_back (
   input  logic                clock,
   input  logic                reset,
   input  bpcw_pkg::cfg_type   cfg,
   input  logic                entry_valid,
   input  bpcw_pkg::entry_type entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_byte
   output logic                rsp_tuser,   // is_crc
   output logic                rsp_tlast    // packet_end
);

   logic [23:0] crc_ff,   crc_in;
   logic [7:0]  wht_ff,   wht_in;
   logic [1:0]  left_ff,  left_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff,  byte_in;
   logic        crc_flag_ff, crc_flag_in;
   logic        end_ff,   end_in;

   logic        out_free;
   logic [23:0] crc_base;
   logic [7:0]  wht_base;
   logic [7:0]  crc_byte;

   assign out_free = !valid_ff || rsp_tready;
   assign pop      = out_free && (left_ff == '0) && entry_valid;

   // Reload CRC and whitener at the first byte of a packet
   assign crc_base = entry.first ? cfg.crc_init : crc_ff;
   assign wht_base = entry.first ? bpcw_pkg::whiten_seed(cfg.channel) : wht_ff;

   // Pick the CRC byte, high byte first
   always_comb begin
      case (left_ff)
         2'd3:    crc_byte = crc_ff[23:16];
         2'd2:    crc_byte = crc_ff[15:8];
         default: crc_byte = crc_ff[7:0];
      endcase
   end

   // Emit a CRC byte or a payload byte when the output stage frees up
   always_comb begin
      crc_in      = crc_ff;
      wht_in      = wht_ff;
      left_in     = left_ff;
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      crc_flag_in = crc_flag_ff;
      end_in      = end_ff;
      if (out_free) begin
         valid_in = 1'b0;
         if (left_ff != '0) begin
            byte_in     = bpcw_pkg::rev8(bpcw_pkg::rev8(crc_byte) ^
                                         bpcw_pkg::whiten_mask(wht_ff));
            wht_in      = bpcw_pkg::whiten_next(wht_ff);
            left_in     = left_ff - 1'b1;
            valid_in    = 1'b1;
            crc_flag_in = 1'b1;
            end_in      = (left_ff == 2'd1);
         end else if (entry_valid) begin
            byte_in     = bpcw_pkg::rev8(entry.data ^ bpcw_pkg::whiten_mask(wht_base));
            wht_in      = bpcw_pkg::whiten_next(wht_base);
            crc_in      = bpcw_pkg::crc_feed(crc_base, entry.data);
            left_in     = entry.last ? bpcw_pkg::CRC_BYTES : 2'd0;
            valid_in    = 1'b1;
            crc_flag_in = 1'b0;
            end_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
   end

   // Hold datapath state and the output payload
   always_ff @(posedge clock) begin
      crc_ff      <= crc_in;
      wht_ff      <= wht_in;
      byte_ff     <= byte_in;
      crc_flag_ff <= crc_flag_in;
      end_ff      <= end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = crc_flag_ff;
   assign rsp_tlast  = end_ff;

endmodule

@@ sv/ble_packet_crc_whiten_encoder.sv @@
// A payload byte goes from req through a queue entry and the engine's output
// register to rsp. Throughput: one payload byte per cycle while rsp_tready is
// high; the three CRC bytes after a packet's last byte hold the engine.
// A four-entry queue between the input stage and the engine absorbs stalls.
// Reset (synchronous, active high) empties the queue, closes any open packet
// and restores channel 37 and CRC start value 0x555555.
module ble_packet_crc_whiten_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // is_crc
   output logic        rsp_tlast,   // packet_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [23:0] csr_data
);

   logic [5:0]          channel_ff,  channel_in;
   logic [23:0]         crc_init_ff, crc_init_in;
   bpcw_pkg::cfg_type   cfg;
   bpcw_pkg::entry_type push_entry;
   bpcw_pkg::entry_type pop_entry;
   logic                push;
   logic                pop;
   logic                fifo_full;
   logic                pop_valid;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      channel_in  = channel_ff;
      crc_init_in = crc_init_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpcw_pkg::CSR_CHANNEL:  channel_in  = csr_data[5:0];
            bpcw_pkg::CSR_CRC_INIT: crc_init_in = csr_data;
            default:                channel_in  = channel_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff  <= bpcw_pkg::CHANNEL_RESET;
         crc_init_ff <= bpcw_pkg::CRC_INIT_RESET;
      end else begin
         channel_ff  <= channel_in;
         crc_init_ff <= crc_init_in;
      end
   end

   assign cfg.channel  = channel_ff;
   assign cfg.crc_init = crc_init_ff;

   bpcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   bpcw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   bpcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ sv/bpcw_checker.sv @@
module bpcw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_ready
);

   // Stalled output holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // Packet end only on a CRC byte
   a_end_is_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("packet end on a payload byte");

   // CRC bytes follow each other without a gap
   a_crc_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast |=> rsp_tvalid && rsp_tuser)
      else $error("gap inside the CRC bytes");

   // Register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port stalled");

endmodule

bind ble_packet_crc_whiten_encoder bpcw_checker u_bpcw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);
